FILE: hdl/indexed_min_heap_queue_defines.svh
// Assertion macros shared by the heap queue RTL.
// Each macro clocks on clk_i and is disabled while rst_ni is low.
`ifndef INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IMHQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IMHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/imhq_pkg.sv
// Package for the indexed min-heap queue: field widths, command and error codes,
// the heap slot type and the command/status structs between controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

package imhq_pkg;

  localparam int ID_W = 12;
  localparam int KEY_W = 32;
  localparam int DIR_W = 2;
  localparam int CNT_W = 11;
  localparam int CMD_W = 3;
  localparam int ERR_W = 2;
  localparam int ID_SPACE = 4096;

  localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEC_KEY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INC_KEY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd6;

  localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_ABSENT = 2'd3;

  // Tag code of an entry without direction (-1 in two bits).
  localparam logic [DIR_W-1:0] DIR_NONE = 2'b11;

  // One heap slot.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic [DIR_W-1:0] dir;
  } slot_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH_SET,
    OP_POP_SET,
    OP_FETCH,
    OP_LOAD_E,
    OP_REPL_SET,
    OP_UP_RD,
    OP_UP_MOVE,
    OP_DN_RD,
    OP_DN_MOVE,
    OP_PUT,
    OP_TOP_RD,
    OP_RESULT,
    OP_CLR_STEP,
    OP_COUNT_ZERO
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [ERR_W-1:0] err;
  } dp_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             last_one;
    logic             present;
    logic             i_zero;
    logic             up_less;
    logic             l_in;
    logic             dn_less;
    logic             clr_done;
    logic             out_free;
  } dp_sts_t;

  // Tags 0 and 1 are kept, anything else stores the no-direction code.
  function automatic logic [DIR_W-1:0] dir_code(input logic [DIR_W-1:0] tag);
    logic [DIR_W-1:0] res;
    res = ((tag == 2'd0) || (tag == 2'd1)) ? tag : DIR_NONE;
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/imhq_ctrl.sv
// Controller state machine of the heap queue: decodes a command word and
// sequences the datapath operations. Depends on imhq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imhq_ctrl
  import imhq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output dp_ctl_t ctl_o,
  input  dp_sts_t sts_i
);

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DEC    = 4'd2;
  localparam logic [3:0] ST_LD     = 4'd3;
  localparam logic [3:0] ST_UP_RD  = 4'd4;
  localparam logic [3:0] ST_UP_CMP = 4'd5;
  localparam logic [3:0] ST_DN_RD  = 4'd6;
  localparam logic [3:0] ST_DN_CMP = 4'd7;
  localparam logic [3:0] ST_PUT    = 4'd8;
  localparam logic [3:0] ST_TOP    = 4'd9;
  localparam logic [3:0] ST_RES    = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [ERR_W-1:0] err_q, err_d;
  logic             reply_q, reply_d;

  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and operation select.
  always_comb begin
    state_d   = state_q;
    err_d     = err_q;
    reply_d   = reply_q;
    ctl_o.op  = OP_NONE;
    ctl_o.err = err_q;
    unique case (state_q)
      ST_CLR: begin
        ctl_o.op = OP_CLR_STEP;
        if (sts_i.clr_done) begin
          reply_d = 1'b0;
          state_d = reply_q ? ST_TOP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.op = OP_LOAD;
          err_d    = ERR_OK;
          state_d  = ST_DEC;
        end
      end
      ST_DEC: begin
        unique case (sts_i.cmd)
          CMD_PUSH: begin
            if (sts_i.full || sts_i.present) begin
              err_d   = ERR_FULL;
              state_d = ST_TOP;
            end else begin
              ctl_o.op = OP_PUSH_SET;
              state_d  = ST_UP_RD;
            end
          end
          CMD_POP: begin
            if (sts_i.empty) begin
              err_d   = ERR_EMPTY;
              state_d = ST_TOP;
            end else begin
              ctl_o.op = OP_POP_SET;
              state_d  = sts_i.last_one ? ST_TOP : ST_DN_RD;
            end
          end
          CMD_DEC_KEY, CMD_INC_KEY: begin
            if (!sts_i.present) begin
              err_d   = ERR_ABSENT;
              state_d = ST_TOP;
            end else begin
              ctl_o.op = OP_FETCH;
              state_d  = ST_LD;
            end
          end
          CMD_REPLACE: begin
            if (sts_i.empty) begin
              err_d   = ERR_EMPTY;
              state_d = ST_TOP;
            end else begin
              ctl_o.op = OP_REPL_SET;
              state_d  = ST_DN_RD;
            end
          end
          CMD_CLEAR: begin
            ctl_o.op = OP_COUNT_ZERO;
            reply_d  = 1'b1;
            state_d  = ST_CLR;
          end
          default: begin
            state_d = ST_TOP;
          end
        endcase
      end
      ST_LD: begin
        ctl_o.op = OP_LOAD_E;
        state_d  = ST_UP_RD;
      end
      ST_UP_RD: begin
        if (sts_i.i_zero) begin
          state_d = ST_DN_RD;
        end else begin
          ctl_o.op = OP_UP_RD;
          state_d  = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (sts_i.up_less) begin
          ctl_o.op = OP_UP_MOVE;
          state_d  = ST_UP_RD;
        end else begin
          state_d = ST_DN_RD;
        end
      end
      ST_DN_RD: begin
        if (sts_i.l_in) begin
          ctl_o.op = OP_DN_RD;
          state_d  = ST_DN_CMP;
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_DN_CMP: begin
        if (sts_i.dn_less) begin
          ctl_o.op = OP_DN_MOVE;
          state_d  = ST_DN_RD;
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        ctl_o.op = OP_PUT;
        state_d  = ST_TOP;
      end
      ST_TOP: begin
        ctl_o.op = OP_TOP_RD;
        state_d  = ST_RES;
      end
      ST_RES: begin
        if (sts_i.out_free) begin
          ctl_o.op = OP_RESULT;
          state_d  = ST_IDLE;
        end else begin
          ctl_o.op = OP_TOP_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      err_q   <= ERR_OK;
      reply_q <= 1'b0;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
      reply_q <= reply_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/imhq_datapath.sv
// Datapath of the heap queue: slot memory, position table, moving entry,
// index and count registers, and the result register. Depends on imhq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imhq_datapath
  import imhq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_ctl_t                 ctl_i,
  output dp_sts_t                 sts_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic [ID_W-1:0]         entry_id_i,
  input  logic [KEY_W-1:0]        key_value_i,
  input  logic signed [DIR_W-1:0] dir_tag_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ID_W-1:0]         top_id_o,
  output logic [KEY_W-1:0]        top_key_o,
  output logic signed [DIR_W-1:0] top_dir_o,
  output logic [CNT_W-1:0]        entry_count_o,
  output logic                    no_entry_o,
  output logic [ERR_W-1:0]        error_code_o
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = SW + 2;

  // Memories: heap slots and the id to {present, slot} table.
  slot_t       slot_mem [CAPACITY];
  logic [SW:0] pos_mem  [ID_SPACE];

  logic [CMD_W-1:0] cmd_q;
  logic [ID_W-1:0]  id_q;
  logic [KEY_W-1:0] key_q;
  logic [DIR_W-1:0] dir_q;
  logic [SW:0]      pos_rd_q;
  slot_t            rda_q, rdb_q;
  slot_t            e_q, e_d;
  logic [SW-1:0]    i_q, i_d;
  logic [CW-1:0]    count_q, count_d;
  logic             popped_q, popped_d;
  logic [ID_W-1:0]  popped_id_q, popped_id_d;
  logic [ID_W-1:0]  clr_ctr_q, clr_ctr_d;
  logic             out_valid_q, out_valid_d;

  logic [ID_W-1:0]  top_id_q;
  logic [KEY_W-1:0] top_key_q;
  logic [DIR_W-1:0] top_dir_q;
  logic [CNT_W-1:0] cnt_out_q;
  logic             empty_q;
  logic [ERR_W-1:0] err_q;

  logic [SW-1:0] ra_a, ra_b;
  logic          re_a, re_b, pos_re;
  logic          slot_we;
  logic [SW-1:0] slot_wa;
  slot_t         slot_wd;
  logic          pos_we;
  logic [ID_W-1:0] pos_wa;
  logic [SW:0]   pos_wd;

  logic [SW-1:0] parent_w;
  logic [LW-1:0] l_w, r_w, cnt_w;
  logic          l_in, r_in, pick_r;
  slot_t         child;
  logic [SW-1:0] child_idx;
  logic          out_free;

  // Tree neighbors of the current index.
  assign parent_w  = (i_q - SW'(1)) >> 1;
  assign l_w       = {1'b0, i_q, 1'b1};
  assign r_w       = l_w + LW'(1);
  assign cnt_w     = LW'(count_q);
  assign l_in      = (l_w < cnt_w);
  assign r_in      = (r_w < cnt_w);
  assign pick_r    = r_in && (rdb_q.key < rda_q.key);
  assign child     = pick_r ? rdb_q : rda_q;
  assign child_idx = pick_r ? r_w[SW-1:0] : l_w[SW-1:0];
  assign out_free  = !out_valid_q || !out_stall_i;

  // Status toward the controller.
  always_comb begin
    sts_o.cmd      = cmd_q;
    sts_o.full     = (count_q >= CW'(CAPACITY));
    sts_o.empty    = (count_q == '0);
    sts_o.last_one = (count_q == CW'(1));
    sts_o.present  = pos_rd_q[SW];
    sts_o.i_zero   = (i_q == '0);
    sts_o.up_less  = (e_q.key < rda_q.key);
    sts_o.l_in     = l_in;
    sts_o.dn_less  = (child.key < e_q.key);
    sts_o.clr_done = (clr_ctr_q == ID_W'(ID_SPACE - 1));
    sts_o.out_free = out_free;
  end

  // Operation decode: memory accesses and register updates.
  always_comb begin
    ra_a        = '0;
    ra_b        = '0;
    re_a        = 1'b0;
    re_b        = 1'b0;
    pos_re      = 1'b0;
    slot_we     = 1'b0;
    slot_wa     = i_q;
    slot_wd     = e_q;
    pos_we      = 1'b0;
    pos_wa      = e_q.id;
    pos_wd      = {1'b1, i_q};
    e_d         = e_q;
    i_d         = i_q;
    count_d     = count_q;
    popped_d    = popped_q;
    popped_id_d = popped_id_q;
    clr_ctr_d   = clr_ctr_q;
    unique case (ctl_i.op)
      OP_LOAD: begin
        ra_a     = '0;
        ra_b     = count_q[SW-1:0] - SW'(1);
        re_a     = 1'b1;
        re_b     = 1'b1;
        pos_re   = 1'b1;
        popped_d = 1'b0;
      end
      OP_PUSH_SET: begin
        e_d     = '{id: id_q, key: key_q, dir: dir_code(dir_q)};
        i_d     = count_q[SW-1:0];
        count_d = count_q + CW'(1);
        pos_we  = 1'b1;
        pos_wa  = id_q;
        pos_wd  = {1'b1, count_q[SW-1:0]};
      end
      OP_POP_SET: begin
        popped_d    = 1'b1;
        popped_id_d = rda_q.id;
        pos_we      = 1'b1;
        pos_wa      = rda_q.id;
        pos_wd      = '0;
        e_d         = rdb_q;
        count_d     = count_q - CW'(1);
        i_d         = '0;
      end
      OP_FETCH: begin
        ra_a = pos_rd_q[SW-1:0];
        re_a = 1'b1;
        i_d  = pos_rd_q[SW-1:0];
      end
      OP_LOAD_E: begin
        e_d = '{id: rda_q.id, key: key_q, dir: rda_q.dir};
      end
      OP_REPL_SET: begin
        e_d = '{id: rda_q.id, key: key_q, dir: rda_q.dir};
        i_d = '0;
      end
      OP_UP_RD: begin
        ra_a = parent_w;
        re_a = 1'b1;
      end
      OP_UP_MOVE: begin
        slot_we = 1'b1;
        slot_wd = rda_q;
        pos_we  = 1'b1;
        pos_wa  = rda_q.id;
        i_d     = parent_w;
      end
      OP_DN_RD: begin
        ra_a = l_w[SW-1:0];
        ra_b = r_w[SW-1:0];
        re_a = 1'b1;
        re_b = 1'b1;
      end
      OP_DN_MOVE: begin
        slot_we = 1'b1;
        slot_wd = child;
        pos_we  = 1'b1;
        pos_wa  = child.id;
        i_d     = child_idx;
      end
      OP_PUT: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
      end
      OP_TOP_RD: begin
        ra_a = '0;
        re_a = 1'b1;
      end
      OP_CLR_STEP: begin
        pos_we    = 1'b1;
        pos_wa    = clr_ctr_q;
        pos_wd    = '0;
        clr_ctr_d = sts_o.clr_done ? '0 : clr_ctr_q + ID_W'(1);
      end
      OP_COUNT_ZERO: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Output valid: set on a new result, dropped when the word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.op == OP_RESULT) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Slot memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (re_a) begin
      rda_q <= slot_mem[ra_a];
    end
    if (re_b) begin
      rdb_q <= slot_mem[ra_b];
    end
  end

  // Position table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    if (pos_re) begin
      pos_rd_q <= pos_mem[entry_id_i];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    e_q         <= e_d;
    i_q         <= i_d;
    popped_id_q <= popped_id_d;
    if (ctl_i.op == OP_LOAD) begin
      cmd_q <= command_i;
      id_q  <= entry_id_i;
      key_q <= key_value_i;
      dir_q <= dir_tag_i;
    end
    if (ctl_i.op == OP_RESULT) begin
      top_id_q  <= popped_q ? popped_id_q : ((count_q != '0) ? rda_q.id : '0);
      top_key_q <= (count_q != '0) ? rda_q.key : '0;
      top_dir_q <= (count_q != '0) ? rda_q.dir : DIR_NONE;
      cnt_out_q <= CNT_W'(count_q);
      empty_q   <= (count_q == '0);
      err_q     <= ctl_i.err;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      popped_q    <= 1'b0;
      clr_ctr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      popped_q    <= popped_d;
      clr_ctr_q   <= clr_ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign top_id_o      = top_id_q;
  assign top_key_o     = top_key_q;
  assign top_dir_o     = top_dir_q;
  assign entry_count_o = cnt_out_q;
  assign no_entry_o    = empty_q;
  assign error_code_o  = err_q;

endmodule

`default_nettype wire

FILE: hdl/indexed_min_heap_queue.sv
// Top level of the indexed min-heap queue: joins controller and datapath.
// Depends on imhq_pkg, imhq_ctrl, imhq_datapath and the defines header.
//
//   Channel  Handshake            Word
//   in       in_valid_i/stall_o   command, entry_id, key_value, dir_tag
//   out      out_valid_o/stall_i  top_id, top_key, top_dir, entry_count, no_entry, error_code
//
// One word at a time. Peek and rejected commands go from decode straight to the top
// read and the result; a command that changes the heap walks the slot memory level
// by level as needed, moving its entry up toward the root, down toward the leaves or both.
// After reset, a clearing pass runs over all 4096 entries of the position table
// before the first word is taken; a clear command runs the same pass.
// A stalled output holds its word while the next input word is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_min_heap_queue_defines.svh"

module indexed_min_heap_queue
  import imhq_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic [ID_W-1:0]         entry_id_i,
  input  logic [KEY_W-1:0]        key_value_i,
  input  logic signed [DIR_W-1:0] dir_tag_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ID_W-1:0]         top_id_o,
  output logic [KEY_W-1:0]        top_key_o,
  output logic signed [DIR_W-1:0] top_dir_o,
  output logic [CNT_W-1:0]        entry_count_o,
  output logic                    no_entry_o,
  output logic [ERR_W-1:0]        error_code_o
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  // Sequencer.
  imhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ctl_o      (ctl),
    .sts_i      (sts)
  );

  // Memories and registers.
  imhq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .command_i     (command_i),
    .entry_id_i    (entry_id_i),
    .key_value_i   (key_value_i),
    .dir_tag_i     (dir_tag_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .top_id_o      (top_id_o),
    .top_key_o     (top_key_o),
    .top_dir_o     (top_dir_o),
    .entry_count_o (entry_count_o),
    .no_entry_o    (no_entry_o),
    .error_code_o  (error_code_o)
  );

  // One word in flight: an accepted word closes the input until it is done.
  `IMHQ_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o, "second word taken")
  // The empty flag agrees with the count.
  `IMHQ_ASSERT_SAME(a_empty_count, out_valid_o, no_entry_o == (entry_count_o == '0), "empty flag mismatch")
  // An empty error only comes from an empty heap.
  `IMHQ_ASSERT_SAME(a_err_empty, out_valid_o && (error_code_o == ERR_EMPTY), no_entry_o, "empty error on filled heap")

endmodule

`default_nettype wire
